/* rtl/core/sct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sine/cosine Taylor unit
// Fixed-point constants of the range reduction, the series coefficient
// table and the per-item sideband carried down the cell chain.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Range reduction constants, Q56 rounded to nearest
  localparam logic [63:0] PI_Q56      = 64'h03243F6A8885A309;
  localparam logic [63:0] TAU_Q56     = 64'h06487ED5110B4612;
  localparam logic [63:0] HALF_PI_Q56 = 64'h01921FB54442D184;
  // Reciprocal of two pi, floored Q0.32
  localparam logic [29:0] INV_TAU_Q32 = 30'd683565275;

  localparam logic [61:0] ONE_Q60 = 62'h1000000000000000;
  localparam logic [31:0] ONE_Q30 = 32'h40000000;

  // round(2^60 / k!) for k = 0..15
  localparam logic [63:0] INV_FACT_Q60 [16] = '{
    64'd1152921504606846976, 64'd1152921504606846976, 64'd576460752303423488,
    64'd192153584101141163,  64'd48038396025285291,   64'd9607679205057058,
    64'd1601279867509510,    64'd228754266787073,     64'd28594283348384,
    64'd3177142594265,       64'd317714259426,        64'd28883114493,
    64'd2406926208,          64'd185148170,           64'd13224869,
    64'd881658
  };

  // Per-item data that travels alongside the series value
  typedef struct packed {
    logic        func;  // 1 selects sine
    logic        neg;   // result sign so far
    logic [60:0] x;     // reduced angle, Q60
    logic [61:0] y;     // x squared, Q60
  } side_t;

  // Signed Horner coefficient of step t: alternating sign, odd index for sine
  function automatic logic [63:0] series_coef(input logic [2:0] t, input logic is_sine);
    logic [63:0] c;
    c = INV_FACT_Q60[{t, is_sine}];
    series_coef = t[0] ? (64'd0 - c) : c;
  endfunction

endpackage

/* rtl/core/sct_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_reduce: range reduction to the first quadrant
// Seven stages: magnitude, reciprocal estimate, quotient product,
// correction, remainder wrap, reflection about pi, reflection about half pi.
// ----------------------------------------------------------------------------
module sct_reduce (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [31:0]    angle_i,
  input  logic           func_i,
  output logic           valid_o,
  output sct_pkg::side_t side_o
);
  import sct_pkg::*;

  logic [7:1]  vld_q;
  logic [6:1]  neg_q;
  logic [6:1]  func_q;

  logic [31:0] mag1_d, mag1_q, mag2_q;
  logic [61:0] qprod;
  logic [5:0]  quo2_d, quo2_q;
  logic [63:0] prod3_d, prod3_q, num3_q;
  logic [63:0] rem4_d, rem4_q, rem5_d, rem5_q, rem6_d, rem6_q, rem7;
  logic        neg6_d, neg7_d;
  side_t       side_d, side_q;

  // Magnitude; the most negative angle maps onto 2^31 by wraparound
  assign mag1_d  = angle_i[31] ? (32'd0 - angle_i) : angle_i;
  assign qprod   = {30'd0, mag1_q} * {32'd0, INV_TAU_Q32};
  assign quo2_d  = qprod[61:56];
  assign prod3_d = {58'd0, quo2_q} * TAU_Q56;

  always_comb begin
    // Step back one quotient when the estimate overshoots
    if (prod3_q > num3_q) begin
      rem4_d = num3_q - prod3_q + TAU_Q56;
    end else begin
      rem4_d = num3_q - prod3_q;
    end
    rem5_d = (rem4_q >= TAU_Q56) ? (rem4_q - TAU_Q56) : rem4_q;
    rem6_d = rem5_q;
    neg6_d = neg_q[5];
    if (rem5_q > PI_Q56) begin
      rem6_d = TAU_Q56 - rem5_q;
      neg6_d = neg_q[5] ^ func_q[5];
    end
    rem7   = rem6_q;
    neg7_d = neg_q[6];
    if (rem6_q > HALF_PI_Q56) begin
      rem7   = PI_Q56 - rem6_q;
      neg7_d = neg_q[6] ^ ~func_q[6];
    end
    side_d.func = func_q[6];
    side_d.neg  = neg7_d;
    side_d.x    = {rem7[56:0], 4'd0};
    side_d.y    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag1_d;
      neg_q   <= {neg6_d, neg_q[4:1], angle_i[31] & func_i};
      func_q  <= {func_q[5:1], func_i};
      mag2_q  <= mag1_q;
      quo2_q  <= quo2_d;
      prod3_q <= prod3_d;
      num3_q  <= {mag2_q, 32'd0};
      rem4_q  <= rem4_d;
      rem5_q  <= rem5_d;
      rem6_q  <= rem6_d;
      side_q  <= side_d;
    end
  end

  assign valid_o = vld_q[7];
  assign side_o  = side_q;

endmodule

/* rtl/core/sct_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_cell: one multiply-add cell of the series chain
// h_o = round(h_i * op_i / 2^60) + add_i, rounded on the magnitude, in four
// stages: magnitude, partial products, sum and round, sign and addend.
// ----------------------------------------------------------------------------
module sct_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  sct_pkg::side_t side_i,
  input  logic [63:0]    h_i,
  input  logic [61:0]    op_i,
  input  logic [63:0]    add_i,
  output logic           valid_o,
  output sct_pkg::side_t side_o,
  output logic [63:0]    h_o
);
  import sct_pkg::*;

  logic [4:1]   vld_q;
  side_t        side1_q, side2_q, side3_q, side4_q;
  logic [63:0]  add1_q, add2_q, add3_q;
  logic [3:1]   neg_q;
  logic [63:0]  mag1_q;
  logic [61:0]  op1_q;
  logic [63:0]  p00_q, p10_q;
  logic [61:0]  p01_q, p11_q;
  logic [125:0] acc;
  logic [63:0]  rnd3_q, h4_d, h4_q;

  assign acc = {p11_q, 64'd0} + {32'd0, p01_q, 32'd0} + {30'd0, p10_q, 32'd0}
             + {62'd0, p00_q} + {66'd0, 1'b1, 59'd0};
  assign h4_d = (neg_q[3] ? (64'd0 - rnd3_q) : rnd3_q) + add3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      side2_q <= side1_q;
      side3_q <= side2_q;
      side4_q <= side3_q;
      add1_q  <= add_i;
      add2_q  <= add1_q;
      add3_q  <= add2_q;
      neg_q   <= {neg_q[2:1], h_i[63]};
      mag1_q  <= h_i[63] ? (64'd0 - h_i) : h_i;
      op1_q   <= op_i;
      p00_q   <= {32'd0, mag1_q[31:0]}  * {32'd0, op1_q[31:0]};
      p01_q   <= {30'd0, mag1_q[31:0]}  * {32'd0, op1_q[61:32]};
      p10_q   <= {32'd0, mag1_q[63:32]} * {32'd0, op1_q[31:0]};
      p11_q   <= {30'd0, mag1_q[63:32]} * {32'd0, op1_q[61:32]};
      rnd3_q  <= acc[123:60];
      h4_q    <= h4_d;
    end
  end

  assign valid_o = vld_q[4];
  assign side_o  = side4_q;
  assign h_o     = h4_q;

endmodule

/* rtl/core/sct_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_round: final rounding to Q2.30
// Register the magnitude and sign, then round half away from zero,
// saturate to one and apply the sign.
// ----------------------------------------------------------------------------
module sct_round (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] h_i,
  input  logic        neg_i,
  output logic        valid_o,
  output logic [31:0] value_o
);
  import sct_pkg::*;

  logic        vld_q;
  logic [63:0] mag_q, rnd;
  logic        neg_q;
  logic [33:0] res;
  logic [31:0] sat;

  assign rnd     = mag_q + {34'd0, 1'b1, 29'd0};
  assign res     = rnd[63:30];
  assign sat     = (res > {2'd0, ONE_Q30}) ? ONE_Q30 : res[31:0];
  assign value_o = neg_q ? (32'd0 - sat) : sat;
  assign valid_o = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= h_i[63] ? (64'd0 - h_i) : h_i;
      neg_q <= neg_i ^ h_i[63];
    end
  end

endmodule

/* rtl/core/sine_cosine_taylor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_taylor: pipelined sine/cosine by Taylor series
// Reduce a Q8.24 angle to the first quadrant, square it, run Horner's rule
// through a row of identical multiply-add cells and round to Q2.30.
// ----------------------------------------------------------------------------
//  channel   | dir | fields (low bit first)                  | accept
//  ----------+-----+-----------------------------------------+-----------------
//  s_axis    | in  | tdata: angle[31:0] Q8.24; tuser: func   | tvalid & tready
//  m_axis    | out | tdata: value[31:0] Q2.30                | tvalid & tready
//
//  One beat in per cycle while the skid register is free. An item runs from
//  input accept to output valid through seven reduction stages, four stages
//  per cell, one round stage and the output register. The cell chain is the
//  square cell, SERIES_TERMS - 1 Horner cells and a final cell that multiplies
//  by x for sine or by one for cosine.
//  Reset clears only valid flags; the datapath holds no state across items.
//  A beat that arrives while the output is stalled parks in a skid register;
//  only when that is full does the whole chain hold and s_axis_tready drop.
// ----------------------------------------------------------------------------
module sine_cosine_taylor #(
  parameter int SERIES_TERMS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] angle
  input  logic        s_axis_tuser,   // [0] func: 0 cosine, 1 sine
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] value
);
  import sct_pkg::*;

  // Clamp the term count to what the coefficient table supports
  localparam int TERMS_C = (SERIES_TERMS > 8) ? 8 : ((SERIES_TERMS < 1) ? 1 : SERIES_TERMS);
  localparam int NCELL   = TERMS_C + 1;

  logic        adv;
  logic        red_valid;
  side_t       red_side;

  logic        c_valid [NCELL];
  side_t       c_side  [NCELL];
  logic [63:0] c_h     [NCELL];
  logic [61:0] c_op    [NCELL];
  logic [63:0] c_add   [NCELL];
  logic        o_valid [NCELL];
  side_t       o_side  [NCELL];
  logic [63:0] o_h     [NCELL];

  logic        pipe_valid;
  logic [31:0] pipe_value;

  logic        out_v_d, out_v_q, skid_v_d, skid_v_q;
  logic [31:0] out_data_d, out_data_q, skid_data_d, skid_data_q;

  // Advance everything while the skid register is free
  assign adv           = ~skid_v_q;
  assign s_axis_tready = adv;

  sct_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid & adv),
    .angle_i (s_axis_tdata),
    .func_i  (s_axis_tuser),
    .valid_o (red_valid),
    .side_o  (red_side)
  );

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    if (j == 0) begin : g_square
      // First cell squares x
      assign c_valid[j] = red_valid;
      assign c_side[j]  = red_side;
      assign c_h[j]     = {3'd0, red_side.x};
      assign c_op[j]    = {1'b0, red_side.x};
      assign c_add[j]   = '0;
    end else begin : g_link
      if (j == 1) begin : g_seed
        // Pick up x squared; seed Horner with the top coefficient
        assign c_side[j] = '{func: o_side[0].func, neg: o_side[0].neg,
                             x: o_side[0].x, y: o_h[0][61:0]};
        assign c_h[j]    = series_coef(3'(TERMS_C - 1), o_side[0].func);
      end else begin : g_pass
        assign c_side[j] = o_side[j-1];
        assign c_h[j]    = o_h[j-1];
      end
      assign c_valid[j] = o_valid[j-1];
      if (j < NCELL - 1) begin : g_horner
        assign c_op[j]  = c_side[j].y;
        assign c_add[j] = series_coef(3'(TERMS_C - 1 - j), c_side[j].func);
      end else begin : g_final
        // Sine takes one more factor of x; cosine multiplies by one
        assign c_op[j]  = c_side[j].func ? {1'b0, c_side[j].x} : ONE_Q60;
        assign c_add[j] = '0;
      end
    end

    sct_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (c_valid[j]),
      .side_i  (c_side[j]),
      .h_i     (c_h[j]),
      .op_i    (c_op[j]),
      .add_i   (c_add[j]),
      .valid_o (o_valid[j]),
      .side_o  (o_side[j]),
      .h_o     (o_h[j])
    );
  end

  sct_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (o_valid[NCELL-1]),
    .h_i     (o_h[NCELL-1]),
    .neg_i   (o_side[NCELL-1].neg),
    .valid_o (pipe_valid),
    .value_o (pipe_value)
  );

  // Output register with skid: load when empty or taken, park otherwise
  always_comb begin
    out_v_d     = out_v_q;
    out_data_d  = out_data_q;
    skid_v_d    = skid_v_q;
    skid_data_d = skid_data_q;
    if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_v_d    = 1'b1;
        out_data_d = skid_data_q;
        skid_v_d   = 1'b0;
      end else begin
        out_v_d    = pipe_valid;
        out_data_d = pipe_value;
      end
    end else if (pipe_valid && adv) begin
      skid_v_d    = 1'b1;
      skid_data_d = pipe_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/core/sct_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_checker: port-level checks of the sine/cosine unit
// Saturation range, stall behavior of the output and skid back-pressure.
// ----------------------------------------------------------------------------
module sct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Result never leaves plus or minus one
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata) <= 32'sd1073741824 &&
                       $signed(m_axis_tdata) >= -32'sd1073741824))
    else $error("output beat outside plus or minus one");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed");

  // Input back-pressure only while a result waits
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output pending");

  // Ready returns only after an output beat is taken
  a_ready_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> $past(m_axis_tvalid && m_axis_tready))
    else $error("input ready rose without an output beat");

endmodule

bind sine_cosine_taylor sct_checker u_sct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* verif/sine_cosine_taylor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_taylor_tb: self-checking bench for the sine/cosine Taylor unit
// Angles go in on the input stream with random gaps and the output side
// stalls at random. A fixed-point model of the range reduction and the
// series predicts each value, and the results are checked in order.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_tb;

  localparam int SERIES_TERMS = 8;
  localparam int RANDOM_BEATS = 1050;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;

  localparam logic FUNC_COS = 1'b0;
  localparam logic FUNC_SIN = 1'b1;

  // Q56 angle constants, Q0.32 reciprocal of two pi
  localparam logic [63:0] PI_Q56      = 64'h03243F6A8885A309;
  localparam logic [63:0] TAU_Q56     = 64'h06487ED5110B4612;
  localparam logic [63:0] HALF_PI_Q56 = 64'h01921FB54442D184;
  localparam logic [63:0] INV_TAU_Q32 = 64'd683565275;
  localparam logic [63:0] UNIT_Q30    = 64'd1073741824;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each value at input accept, checks at output accept
  // --------------------------------------------------------------------------
  class trig_scoreboard;
    logic [31:0] expected_values[$];
    logic [31:0] pending_angles[$];
    logic        pending_funcs[$];
    int          mismatches = 0;

    // round(2^60 / k!)
    function logic [63:0] fact_recip_q60(int k);
      case (k)
        0, 1:    return 64'd1152921504606846976;
        2:       return 64'd576460752303423488;
        3:       return 64'd192153584101141163;
        4:       return 64'd48038396025285291;
        5:       return 64'd9607679205057058;
        6:       return 64'd1601279867509510;
        7:       return 64'd228754266787073;
        8:       return 64'd28594283348384;
        9:       return 64'd3177142594265;
        10:      return 64'd317714259426;
        11:      return 64'd28883114493;
        12:      return 64'd2406926208;
        13:      return 64'd185148170;
        14:      return 64'd13224869;
        default: return 64'd881658;
      endcase
    endfunction

    // Unsigned Q60 product, rounded half up
    function logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << 59);
      return p[123:60];
    endfunction

    // Signed Q60 times unsigned Q60, rounded on the magnitude
    function logic [63:0] smul_q60(logic [63:0] a, logic [63:0] b);
      logic [63:0] mag;
      logic [63:0] r;
      mag = a[63] ? (64'd0 - a) : a;
      r = mul_q60(mag, b);
      return a[63] ? (64'd0 - r) : r;
    endfunction

    function logic [31:0] predict_value(logic [31:0] angle, logic func);
      logic        is_sine;
      logic        negative;
      logic [63:0] mag, num, quot, prod, rem, x, y, h, c, m, res;
      int          terms;
      is_sine  = (func == FUNC_SIN);
      negative = 1'b0;
      if (angle[31]) begin
        mag = {32'd0, 32'd0 - angle};
        if (mag == 64'd0)
          mag = 64'h80000000;
        if (is_sine)
          negative = ~negative;
      end else begin
        mag = {32'd0, angle};
      end
      // Remainder modulo two pi, quotient estimate corrected both ways
      num  = mag << 32;
      quot = (mag * INV_TAU_Q32) >> 56;
      prod = quot * TAU_Q56;
      if (prod > num)
        prod = prod - TAU_Q56;
      rem = num - prod;
      if (rem >= TAU_Q56)
        rem = rem - TAU_Q56;
      // Fold into the first quadrant
      if (rem > PI_Q56) begin
        rem = TAU_Q56 - rem;
        if (is_sine)
          negative = ~negative;
      end
      if (rem > HALF_PI_Q56) begin
        rem = PI_Q56 - rem;
        if (!is_sine)
          negative = ~negative;
      end
      x = rem << 4;
      y = mul_q60(x, x);
      terms = SERIES_TERMS;
      if (terms > 8)
        terms = 8;
      if (terms < 1)
        terms = 1;
      // Horner's rule in x^2, highest term first
      h = fact_recip_q60(2 * (terms - 1) + (is_sine ? 1 : 0));
      if ((terms - 1) % 2 == 1)
        h = 64'd0 - h;
      for (int t = terms - 2; t >= 0; t--) begin
        c = fact_recip_q60(2 * t + (is_sine ? 1 : 0));
        h = smul_q60(h, y) + ((t % 2 == 1) ? (64'd0 - c) : c);
      end
      if (is_sine)
        h = smul_q60(h, x);
      if (h[63]) begin
        negative = ~negative;
        m = 64'd0 - h;
      end else begin
        m = h;
      end
      res = (m + (64'd1 << 29)) >> 30;
      if (res > UNIT_Q30)
        res = UNIT_Q30;
      return negative ? (32'd0 - res[31:0]) : res[31:0];
    endfunction

    function void note_angle(logic [31:0] angle, logic func);
      expected_values.push_back(predict_value(angle, func));
      pending_angles.push_back(angle);
      pending_funcs.push_back(func);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_value(logic [31:0] got);
      logic [31:0] want;
      logic [31:0] angle;
      logic        func;
      if (expected_values.size() == 0) begin
        report($sformatf("unexpected beat, value %08h", got));
      end else begin
        want  = expected_values.pop_front();
        angle = pending_angles.pop_front();
        func  = pending_funcs.pop_front();
        if (got !== want)
          report($sformatf("angle %08h %s: value %08h, want %08h", angle,
                           (func == FUNC_SIN) ? "sin" : "cos", got, want));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and clock
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] angle
  logic        s_axis_tuser;   // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] value

  trig_scoreboard board;
  bit             send_burst;
  bit             recv_burst;
  int             idle_cycles = 0;

  sine_cosine_taylor #(
    .SERIES_TERMS(SERIES_TERMS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Present one angle after a random gap (none during a burst), hold until the beat is taken
  task send_angle(logic [31:0] angle, logic func);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= angle;
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_angle(angle, func);
  endtask

  // Random angle: full range, small magnitudes, or close to a multiple of
  // half pi where the quadrant folds switch
  function automatic logic [31:0] random_angle();
    int          pick;
    logic [63:0] base;
    logic [31:0] a;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      a = $urandom;
    end else if (pick < 7) begin
      a = $urandom_range(0, 32'h07FFFFFF);
      if ($urandom_range(0, 1))
        a = 32'd0 - a;
    end else begin
      base = (64'($urandom_range(0, 81)) * HALF_PI_Q56) >> 32;
      a = base[31:0] + $urandom_range(0, 64) - 32'd32;
      if (a[31])
        a = 32'd0;
      if ($urandom_range(0, 1))
        a = 32'd0 - a;
    end
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] edge_angles[12];
    board = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 32'd0;
    s_axis_tuser  = FUNC_COS;
    m_axis_tready = 1'b0;
    send_burst    = 1'b0;
    recv_burst    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes and angles on the quadrant boundaries
    edge_angles = '{32'h00000000, 32'h00000001, 32'hFFFFFFFF, 32'h7FFFFFFF,
                    32'h80000000, 32'h03243F6B, 32'hFCDBC095, 32'h01921FB5,
                    32'h01921FB4, 32'h04B65F20, 32'h06487ED5, 32'h06487ED6};
    foreach (edge_angles[i]) begin
      send_angle(edge_angles[i], FUNC_COS);
      send_angle(edge_angles[i], FUNC_SIN);
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // Switch between gapped traffic and back-to-back stretches
      if (n % 50 == 0)
        send_burst = ($urandom_range(0, 3) == 0);
      send_angle(random_angle(), logic'($urandom_range(0, 1)));
    end
    s_axis_tvalid <= 1'b0;

    while (board.expected_values.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: stall at random, check every beat taken
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    int taken;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 50 == 0)
        recv_burst = ($urandom_range(0, 3) == 0);
      gap = recv_burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_value(m_axis_tdata);
      taken++;
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
rtl/core/sct_pkg.sv
rtl/core/sct_reduce.sv
rtl/core/sct_cell.sv
rtl/core/sct_round.sv
rtl/core/sine_cosine_taylor.sv
rtl/core/sct_checker.sv
verif/sine_cosine_taylor_tb.sv
